// ----- rtl/core/seft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seft_pkg
// Shared types, constants and control/status bundles of the exposure and
// frame timing core.
// ----------------------------------------------------------------------------
package seft_pkg;

    localparam int unsigned DIV_W  = 36;
    localparam int unsigned DEN_W  = 16;
    localparam int unsigned FRM_W  = 15;
    localparam int unsigned CNT_W  = $clog2(DIV_W + 1);

    localparam logic [FRM_W-1:0] FRAME_TOP       = 15'h7fff;
    localparam logic [FRM_W-1:0] FRAME_RST       = 15'd1221;
    localparam logic [15:0]      VBLANK_OFFSET   = 16'h04c4;
    localparam logic [32:0]      EXPO_PAD_LINES  = 33'd7;
    localparam logic [31:0]      EXPO_CLAMP_LO   = 32'd4;
    localparam logic [31:0]      EXPO_CLAMP_HI   = 32'd32760;
    localparam logic [31:0]      GAIN_LO         = 32'd1024;
    localparam logic [31:0]      GAIN_HI         = 32'd15872;
    localparam int unsigned      GAIN_SHIFT      = 6;
    localparam logic [7:0]       CODE_LO         = 8'h10;
    localparam logic [7:0]       CODE_HI         = 8'hf8;
    // pclk / 296 = ((pclk >> 3) * RECIP_296) >> 35
    // pclk / 146 = ((pclk >> 1) * RECIP_146) >> 38
    localparam logic [31:0]      RECIP_296       = 32'd928641578;
    localparam logic [31:0]      RECIP_146       = 32'd3765450781;
    localparam logic [DIV_W-1:0] BAND30_LO       = 36'd297;
    localparam logic [DIV_W-1:0] BAND30_HI       = 36'd305;
    localparam logic [DIV_W-1:0] BAND15_LO       = 36'd147;
    localparam logic [DIV_W-1:0] BAND15_HI       = 36'd150;
    localparam logic [DIV_W-1:0] FPS_SAT         = 36'd65535;

    localparam logic [2:0] REG_PCLK    = 3'd0;
    localparam logic [2:0] REG_LP      = 3'd1;
    localparam logic [2:0] REG_BASE    = 3'd2;
    localparam logic [2:0] REG_CAP     = 3'd3;
    localparam logic [2:0] REG_FLICKER = 3'd4;

    typedef enum logic [1:0] {
        CMD_EXPO      = 2'd0,
        CMD_EXPO_KEEP = 2'd1,
        CMD_GAIN      = 2'd2,
        CMD_RATE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DEN_RATE,
        DEN_LP,
        DEN_FRAME
    } t_den_sel;

    typedef enum logic [1:0] {
        NUM_PCLK,
        NUM_Q10,
        NUM_RQ10
    } t_num_sel;

    typedef enum logic [1:0] {
        BAND_NONE,
        BAND_30,
        BAND_15
    } t_band;

    typedef struct packed {
        logic     load;
        logic     do_expo;
        logic     do_gain;
        logic     div_start;
        t_num_sel num_sel;
        t_den_sel den_sel;
        logic     band_load;
        logic     recip_load;
        logic     set_flk_frame;
        logic     commit_expo;
        logic     set_rate_frame;
        logic     set_fps;
        logic     out_load;
    } t_dp_ctl;

    typedef struct packed {
        logic  div_done;
        t_cmd  cmd;
        logic  rate_ok;
        logic  flk_go;
        t_band band;
        logic  frame_zero;
        logic  out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [31:0]      pclk;
        logic [15:0]      line_pixels;
        logic [FRM_W-1:0] base_lines;
        logic [FRM_W-1:0] cap_lines;
        logic             flicker;
    } t_cfg;

endpackage

// ----- rtl/core/seft_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seft_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module seft_div
    import seft_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [DIV_W-1:0] o_quo,
    output logic             o_done
);

    logic [DIV_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_sh;
    logic             n_bit;

    always_comb begin
        n_sh  = {r_rem, r_num[DIV_W-1]};
        n_bit = (n_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], n_bit};
            r_rem <= n_bit ? DEN_W'(n_sh - {1'b0, r_den}) : n_sh[DEN_W-1:0];
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule

// ----- rtl/core/seft_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seft_dp
// Datapath: command latch, frame state, shared divider, result register.
// ----------------------------------------------------------------------------
module seft_dp
    import seft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_dp_ctl     i_ctl,
    output t_dp_sts     o_sts,
    input  logic [1:0]  i_in_cmd,
    input  logic [79:0] i_in_data,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata
);

    t_cmd             r_cmd;
    logic [31:0]      r_expo;
    logic [31:0]      r_gain;
    logic [15:0]      r_rate;
    logic [FRM_W-1:0] r_frame;
    logic [FRM_W-1:0] r_now;
    logic [FRM_W-1:0] r_floor;
    t_band            r_band;
    logic [31:0]      r_recip;
    logic [15:0]      r_res_vblank;
    logic [FRM_W-1:0] r_res_expo;
    logic [7:0]       r_res_gain;
    logic [15:0]      r_res_fps;
    logic             r_res_wf;
    logic             r_res_we;
    logic             r_res_wg;
    logic             r_m_tvalid;
    logic [79:0]      r_m_tdata;

    logic [DIV_W-1:0] w_quo;
    logic             w_done;
    logic [DIV_W-1:0] w_num;
    logic [DEN_W-1:0] w_den;
    logic [DIV_W-1:0] w_q10;
    logic [DIV_W-1:0] w_rq10;
    logic [31:0]      w_ma;
    logic [31:0]      w_mb;
    logic [63:0]      w_rprod;
    logic [31:0]      w_recip;
    logic [32:0]      w_grown;
    logic [32:0]      w_base;
    logic [32:0]      w_big;
    logic [FRM_W-1:0] w_lim;
    logic [FRM_W-1:0] w_xframe;
    logic [31:0]      w_xexpo;
    logic [31:0]      w_gcl;
    logic [7:0]       w_code;
    logic [FRM_W-1:0] w_flk_frame;
    logic [FRM_W-1:0] w_rate_frame;
    logic [15:0]      w_fps;
    t_band            w_band;

    assign w_q10  = {1'b0, w_quo[31:0], 3'b000} + {3'b000, w_quo[31:0], 1'b0};
    assign w_rq10 = {1'b0, r_recip, 3'b000} + {3'b000, r_recip, 1'b0};

    always_comb begin
        if (r_band == BAND_15) begin
            w_ma = {1'b0, i_cfg.pclk[31:1]};
            w_mb = RECIP_146;
        end else begin
            w_ma = {3'b000, i_cfg.pclk[31:3]};
            w_mb = RECIP_296;
        end
        w_rprod = 64'(w_ma) * 64'(w_mb);
        if (r_band == BAND_15) begin
            w_recip = {6'b0, w_rprod[63:38]};
        end else begin
            w_recip = {3'b000, w_rprod[63:35]};
        end
    end

    always_comb begin
        case (i_ctl.num_sel)
            NUM_Q10:  w_num = w_q10;
            NUM_RQ10: w_num = w_rq10;
            default:  w_num = {4'b0000, i_cfg.pclk};
        endcase
        case (i_ctl.den_sel)
            DEN_RATE:  w_den = r_rate;
            DEN_LP:    w_den = i_cfg.line_pixels;
            DEN_FRAME: w_den = {1'b0, r_frame};
            default:   w_den = i_cfg.line_pixels;
        endcase
    end

    seft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_done  (w_done)
    );

    always_comb begin
        w_grown = {1'b0, r_expo} + EXPO_PAD_LINES;
        w_base  = {18'b0, (r_cmd == CMD_EXPO_KEEP) ? r_now : r_floor};
        w_big   = (w_grown > w_base) ? w_grown : w_base;
        w_lim   = (r_cmd == CMD_EXPO_KEEP) ? FRAME_TOP : i_cfg.cap_lines;
        w_xframe = (w_big > {18'b0, w_lim}) ? w_lim : w_big[FRM_W-1:0];
        if (r_expo < EXPO_CLAMP_LO) begin
            w_xexpo = EXPO_CLAMP_LO;
        end else if (r_expo > EXPO_CLAMP_HI) begin
            w_xexpo = EXPO_CLAMP_HI;
        end else begin
            w_xexpo = r_expo;
        end

        if (r_gain < GAIN_LO) begin
            w_gcl = GAIN_LO;
        end else if (r_gain > GAIN_HI) begin
            w_gcl = GAIN_HI;
        end else begin
            w_gcl = r_gain;
        end
        w_code = 8'(w_gcl >> GAIN_SHIFT);
        if (w_code <= CODE_LO) begin
            w_code = CODE_LO;
        end else if (w_code >= CODE_HI) begin
            w_code = CODE_HI;
        end

        if (w_quo < {21'b0, r_floor}) begin
            w_flk_frame = r_floor;
        end else if (w_quo > {21'b0, FRAME_TOP}) begin
            w_flk_frame = FRAME_TOP;
        end else begin
            w_flk_frame = w_quo[FRM_W-1:0];
        end

        if (w_quo < {21'b0, i_cfg.base_lines}) begin
            w_rate_frame = i_cfg.base_lines;
        end else if (w_quo > {21'b0, FRAME_TOP}) begin
            w_rate_frame = FRAME_TOP;
        end else begin
            w_rate_frame = w_quo[FRM_W-1:0];
        end

        w_fps = (w_quo > FPS_SAT) ? 16'hffff : w_quo[15:0];

        if (w_quo inside {[BAND30_LO:BAND30_HI]}) begin
            w_band = BAND_30;
        end else if (w_quo inside {[BAND15_LO:BAND15_HI]}) begin
            w_band = BAND_15;
        end else begin
            w_band = BAND_NONE;
        end
    end

    always_comb begin
        o_sts.div_done   = w_done;
        o_sts.cmd        = r_cmd;
        o_sts.rate_ok    = (r_rate != '0) && (i_cfg.line_pixels != '0) && (r_now != '0);
        o_sts.flk_go     = i_cfg.flicker && (i_cfg.line_pixels != '0) && (r_frame != '0);
        o_sts.band       = w_band;
        o_sts.frame_zero = (r_frame == '0);
        o_sts.out_free   = !r_m_tvalid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= FRAME_RST;
            r_floor    <= FRAME_RST;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_ctl.commit_expo) begin
                r_now <= r_frame;
            end
            if (i_ctl.set_rate_frame) begin
                r_now   <= w_rate_frame;
                r_floor <= w_rate_frame;
            end
            if (i_ctl.out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd        <= t_cmd'(i_in_cmd);
            r_expo       <= i_in_data[31:0];
            r_gain       <= i_in_data[63:32];
            r_rate       <= i_in_data[79:64];
            r_res_vblank <= '0;
            r_res_expo   <= '0;
            r_res_gain   <= '0;
            r_res_fps    <= '0;
            r_res_wf     <= 1'b0;
            r_res_we     <= 1'b0;
            r_res_wg     <= 1'b0;
        end
        if (i_ctl.do_expo) begin
            r_frame    <= w_xframe;
            r_res_expo <= w_xexpo[FRM_W-1:0];
            r_res_wf   <= 1'b1;
            r_res_we   <= 1'b1;
        end
        if (i_ctl.do_gain) begin
            r_res_gain <= w_code;
            r_res_wg   <= 1'b1;
        end
        if (i_ctl.band_load) begin
            r_band <= w_band;
        end
        if (i_ctl.recip_load) begin
            r_recip <= w_recip;
        end
        if (i_ctl.set_flk_frame) begin
            r_frame <= w_flk_frame;
        end
        if (i_ctl.commit_expo) begin
            r_res_vblank <= {1'b0, r_frame} - VBLANK_OFFSET;
        end
        if (i_ctl.set_rate_frame) begin
            r_frame <= w_rate_frame;
        end
        if (i_ctl.set_fps) begin
            r_res_fps <= w_fps;
        end
        if (i_ctl.out_load) begin
            r_m_tdata <= {7'b0, r_res_wg, r_res_we, r_res_wf, r_res_fps, r_res_gain,
                          r_res_expo, r_res_vblank, r_now};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

// ----- rtl/core/seft_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seft_ctrl
// Command sequencer: orders the divide chains and result hand-off.
// ----------------------------------------------------------------------------
module seft_ctrl
    import seft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ECHK, S_M1, S_M2, S_MCHK, S_FM, S_F1, S_F2, S_CEXP,
        S_R1, S_R2, S_PCHK, S_P1, S_P2, S_OUT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_ctl n_ctl;

    always_comb begin
        n_state = r_state;
        n_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_ctl.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    CMD_EXPO, CMD_EXPO_KEEP: begin
                        n_ctl.do_expo = 1'b1;
                        n_state       = S_ECHK;
                    end
                    CMD_GAIN: begin
                        n_ctl.do_gain = 1'b1;
                        n_state       = S_OUT;
                    end
                    default: begin
                        if (i_sts.rate_ok) begin
                            n_ctl.div_start = 1'b1;
                            n_ctl.num_sel   = NUM_PCLK;
                            n_ctl.den_sel   = DEN_RATE;
                            n_state         = S_R1;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_ECHK: begin
                if (i_sts.flk_go) begin
                    n_ctl.div_start = 1'b1;
                    n_ctl.num_sel   = NUM_PCLK;
                    n_ctl.den_sel   = DEN_LP;
                    n_state         = S_M1;
                end else begin
                    n_state = S_CEXP;
                end
            end
            S_M1: begin
                if (i_sts.div_done) begin
                    n_ctl.div_start = 1'b1;
                    n_ctl.num_sel   = NUM_Q10;
                    n_ctl.den_sel   = DEN_FRAME;
                    n_state         = S_M2;
                end
            end
            S_M2: begin
                if (i_sts.div_done) begin
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                case (i_sts.band)
                    BAND_30, BAND_15: begin
                        n_ctl.band_load = 1'b1;
                        n_state         = S_FM;
                    end
                    default: n_state = S_CEXP;
                endcase
            end
            S_FM: begin
                n_ctl.recip_load = 1'b1;
                n_state          = S_F1;
            end
            S_F1: begin
                n_ctl.div_start = 1'b1;
                n_ctl.num_sel   = NUM_RQ10;
                n_ctl.den_sel   = DEN_LP;
                n_state         = S_F2;
            end
            S_F2: begin
                if (i_sts.div_done) begin
                    n_ctl.set_flk_frame = 1'b1;
                    n_state             = S_CEXP;
                end
            end
            S_CEXP: begin
                n_ctl.commit_expo = 1'b1;
                n_state           = S_OUT;
            end
            S_R1: begin
                if (i_sts.div_done) begin
                    n_ctl.div_start = 1'b1;
                    n_ctl.num_sel   = NUM_Q10;
                    n_ctl.den_sel   = DEN_LP;
                    n_state         = S_R2;
                end
            end
            S_R2: begin
                if (i_sts.div_done) begin
                    n_ctl.set_rate_frame = 1'b1;
                    n_state              = S_PCHK;
                end
            end
            S_PCHK: begin
                if (i_sts.frame_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_ctl.div_start = 1'b1;
                    n_ctl.num_sel   = NUM_PCLK;
                    n_ctl.den_sel   = DEN_FRAME;
                    n_state         = S_P1;
                end
            end
            S_P1: begin
                if (i_sts.div_done) begin
                    n_ctl.div_start = 1'b1;
                    n_ctl.num_sel   = NUM_Q10;
                    n_ctl.den_sel   = DEN_LP;
                    n_state         = S_P2;
                end
            end
            S_P2: begin
                if (i_sts.div_done) begin
                    n_ctl.set_fps = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl      = n_ctl;
    assign o_s_tready = (r_state == S_IDLE);

endmodule

// ----- rtl/core/sensor_exposure_frame_timing_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_exposure_frame_timing_core
// Exposure, gain and frame length command unit of an image sensor.
//
// Channel    Direction  Transaction
// s_axis     in         one command: tuser = command, tdata = exposure/gain/rate
// m_axis     out        one result per command
// apb        in/out     register writes and reads, one register per word
//
// Gain and exposure without anti-flicker use no divide. Each divide runs on
// the shared 36-step divider. Anti-flicker exposure: two divides; a pull-down
// adds a reciprocal multiply and one divide. Max-rate command: up to four
// divides. A new command is taken only once the last result has been loaded
// into the output register. A result waits in the output register; a full
// output register holds the sequencer. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module sensor_exposure_frame_timing_core
    import seft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // exposure_lines[31:0], gain_request, rate_tenths
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // frame_lines, vblank_word, exposure_word,
                                        // gain_word, fps_tenths, wrote_frame,
                                        // wrote_exposure, wrote_gain, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_dp_ctl w_ctl;
    t_dp_sts w_sts;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pclk        <= 32'd16500000;
            r_cfg.line_pixels <= 16'd448;
            r_cfg.base_lines  <= FRAME_RST;
            r_cfg.cap_lines   <= FRAME_TOP;
            r_cfg.flicker     <= 1'b0;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_PCLK:    r_cfg.pclk        <= pwdata;
                REG_LP:      r_cfg.line_pixels <= pwdata[15:0];
                REG_BASE:    r_cfg.base_lines  <= pwdata[FRM_W-1:0];
                REG_CAP:     r_cfg.cap_lines   <= pwdata[FRM_W-1:0];
                REG_FLICKER: r_cfg.flicker     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_PCLK:    prdata = r_cfg.pclk;
            REG_LP:      prdata = {16'b0, r_cfg.line_pixels};
            REG_BASE:    prdata = {17'b0, r_cfg.base_lines};
            REG_CAP:     prdata = {17'b0, r_cfg.cap_lines};
            REG_FLICKER: prdata = {31'b0, r_cfg.flicker};
            default:     prdata = '0;
        endcase
    end

    seft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    seft_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_in_cmd   (s_axis_tuser),
        .i_in_data  (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    a_gain_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[72] && m_axis_tdata[70]))
        else $error("gain and frame writes in one result");

    a_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[70] |->
            m_axis_tdata[30:15] == ({1'b0, m_axis_tdata[14:0]} - VBLANK_OFFSET))
        else $error("vblank word does not follow frame length");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken while busy");

endmodule
